FILE: hw/rtl/bhd_pkg.sv
// bhd_pkg: shared constants, field widths and controller/datapath interface
// structs for the byte histogram drain unit. No dependencies.
package bhd_pkg;

    localparam int SYM_W          = 8;
    localparam int OUT_COUNT_W    = 16;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 24;

    localparam int BINS_DEF       = 256;
    localparam int COUNT_BITS_DEF = 16;

    // marks are searched in groups of this size
    localparam int GRP_SIZE       = 16;
    localparam int GRP_IDX_W      = 4;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic cap_in;     // latch the counted symbol as the working address
        logic rd_en;      // read the counter store
        logic rd_drain;   // read address from the mark search
        logic cap_drain;  // latch search result
        logic cnt_wr;     // write incremented counter and set its mark
        logic dr_clr;     // clear mark of drained bin
        logic load_out;   // load the output register
    } bhd_cmd_t;

    typedef struct packed {
        logic in_op;
        logic in_sym_ok;
        logic out_free;
    } bhd_stat_t;

endpackage

FILE: hw/rtl/bhd_ctrl.sv
// bhd_ctrl: sequencer for count and drain transfers.
// Depends on bhd_pkg (command and status structs, opcodes).
module bhd_ctrl import bhd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bhd_stat_t stat,
    output bhd_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CNT_WR  = 3'd1;
    localparam logic [2:0] ST_DR_SCAN = 3'd2;
    localparam logic [2:0] ST_DR_RD   = 3'd3;
    localparam logic [2:0] ST_DR_TREE = 3'd4;
    localparam logic [2:0] ST_DR_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (stat.in_op == OP_DRAIN) begin
                        state_next = ST_DR_SCAN;
                    end else if (stat.in_sym_ok) begin
                        cmd.cap_in = 1'b1;
                        cmd.rd_en  = 1'b1;
                        state_next = ST_CNT_WR;
                    end
                end
            end
            ST_CNT_WR: begin
                cmd.cnt_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DR_SCAN: begin
                cmd.rd_en     = 1'b1;
                cmd.rd_drain  = 1'b1;
                cmd.cap_drain = 1'b1;
                state_next    = ST_DR_RD;
            end
            ST_DR_RD: begin
                cmd.dr_clr = 1'b1;
                state_next = ST_DR_TREE;
            end
            // group flags pick up the cleared mark here
            ST_DR_TREE: begin
                state_next = ST_DR_OUT;
            end
            ST_DR_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/bhd_dp.sv
// bhd_dp: counter store, nonzero marks, registered two-level mark search
// and output register. Depends on bhd_pkg.
module bhd_dp import bhd_pkg::*; #(
    parameter int BINS       = BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  bhd_cmd_t             cmd,
    output bhd_stat_t            stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [0:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int IDX_W  = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int NGRP   = (BINS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GW     = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD_W  = NGRP * GRP_SIZE;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] mem [BINS];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic [BINS-1:0]       marks_reg;
    logic [PAD_W-1:0]      marks_pad;

    logic [NGRP-1:0]      grp_any_c;
    logic [GRP_IDX_W-1:0] grp_low_c [NGRP];
    logic [NGRP-1:0]      grp_any_reg;
    logic [GRP_IDX_W-1:0] grp_low_reg [NGRP];

    logic                     sel_found;
    logic [GW+GRP_IDX_W-1:0]  sel_wide;
    logic [IDX_W-1:0]         sel_idx;
    logic [IDX_W-1:0]         in_idx;
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         addr_reg;
    logic                     found_reg;

    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [31:0]           cnt32;
    logic [OUT_COUNT_W-1:0] cnt_sat;

    logic                   m_tvalid_reg;
    logic [SYM_W-1:0]       m_sym_reg;
    logic [OUT_COUNT_W-1:0] m_cnt_reg;
    logic                   m_bvalid_reg;
    logic                   m_last_reg;

    assign in_idx         = s_tdata[IDX_W-1:0];
    assign stat.in_op     = s_tuser[0];
    assign stat.in_sym_ok = ({1'b0, s_tdata[SYM_W-1:0]} < (SYM_W + 1)'(BINS));
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign marks_pad = PAD_W'(marks_reg);

    // first level: per-group any flag and lowest marked position
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any_c[g] = |marks_pad[g*GRP_SIZE +: GRP_SIZE];
            grp_low_c[g] = '0;
            for (int l = GRP_SIZE - 1; l >= 0; l--) begin
                if (marks_pad[g*GRP_SIZE + l]) begin
                    grp_low_c[g] = GRP_IDX_W'(l);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_any_reg <= '0;
        end else begin
            grp_any_reg <= grp_any_c;
        end
        for (int g = 0; g < NGRP; g++) begin
            grp_low_reg[g] <= grp_low_c[g];
        end
    end

    // second level: lowest group with a mark
    always_comb begin
        sel_found = 1'b0;
        sel_wide  = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                sel_found = 1'b1;
                sel_wide  = {GW'(g), grp_low_reg[g]};
            end
        end
        sel_idx = sel_wide[IDX_W-1:0];
    end

    assign rd_addr = cmd.rd_drain ? sel_idx : in_idx;

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.cnt_wr) begin
            mem[addr_reg] <= new_cnt;
        end
    end

    // an unmarked bin reads as zero, so the store itself is never cleared
    assign old_cnt = marks_reg[addr_reg] ? rdata_reg : '0;
    assign new_cnt = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            addr_reg <= in_idx;
        end else if (cmd.cap_drain) begin
            addr_reg <= sel_idx;
        end
        if (cmd.cap_drain) begin
            found_reg <= sel_found;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg <= '0;
        end else if (cmd.cnt_wr) begin
            marks_reg[addr_reg] <= 1'b1;
        end else if (cmd.dr_clr && found_reg) begin
            marks_reg[addr_reg] <= 1'b0;
        end
    end

    assign cnt32   = 32'(rdata_reg);
    assign cnt_sat = (cnt32 > 32'h0000_FFFF) ? '1 : cnt32[OUT_COUNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_sym_reg    <= found_reg ? SYM_W'(addr_reg) : '0;
            m_cnt_reg    <= found_reg ? cnt_sat : '0;
            m_bvalid_reg <= found_reg;
            m_last_reg   <= ~|grp_any_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {m_cnt_reg, m_sym_reg};
    assign m_tuser[0] = m_bvalid_reg;
    assign m_tlast    = m_last_reg;

endmodule

FILE: hw/rtl/byte_histogram_drain_unit.sv
// byte_histogram_drain_unit: top level of the byte histogram with drain.
// Depends on bhd_pkg, bhd_ctrl and bhd_dp.
//
//   channel | dir | tdata                          | tuser       | tlast
//   s_      | in  | [7:0] symbol                   | [0] opcode  | -
//   m_      | out | [7:0] bin_symbol, [23:8] count | [0] valid   | drain_last
//
// A count transfer is a counter read, then a saturating write-back.
// A drain transfer is a two-level mark search, counter read, mark
// clear, search refresh for the last flag, output load.
// Out-of-range symbols are dropped in the accepting cycle.
// Reset clears all marks; an unmarked counter reads as zero, so no sweep runs.
// A drain waits in its final step while the output register is still held.
module byte_histogram_drain_unit import bhd_pkg::*; #(
    parameter int BINS       = BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] symbol
    input  logic [0:0]           s_tuser,   // [0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] bin_symbol, [23:8] bin_count
    output logic [0:0]           m_tuser,   // [0] bin_valid
    output logic                 m_tlast    // drain_last
);

    bhd_cmd_t  cmd;
    bhd_stat_t stat;

    bhd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bhd_dp #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // one transfer in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted back to back");

    // an empty drain is always the last one
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("empty drain without last");

    // an empty drain carries zero symbol and count
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("empty drain with nonzero data");

    // a new result is only loaded while the block is busy with a drain
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !s_tready)
        else $error("output load while idle");

endmodule

FILE: sim/tb.sv
// tb: self-checking testbench for byte_histogram_drain_unit.
// Depends on bhd_pkg and the unit's RTL; drives the s_ stream, checks every m_
// transfer against a local model of the 256-bin histogram.
`timescale 1ns / 100ps

module tb;
    import bhd_pkg::*;

    localparam int BINS         = BINS_DEF;
    localparam int COUNT_BITS   = COUNT_BITS_DEF;
    localparam int RANDOM_ITEMS = 480;
    // a long run of count transfers into one bin
    localparam int BURST_LEN    = 200;

    typedef struct packed {
        logic [SYM_W-1:0]       sym;
        logic [OUT_COUNT_W-1:0] count;
        logic                   valid;
        logic                   last;
    } bin_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [7:0] symbol
    logic [0:0]           s_tuser;   // [0] opcode
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [7:0] bin_symbol, [23:8] bin_count
    logic [0:0]           m_tuser;   // [0] bin_valid
    logic                 m_tlast;   // drain_last

    byte_histogram_drain_unit #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    logic [COUNT_BITS-1:0] bin_tally [BINS];
    int unsigned           occupied_bins;
    bin_result_t           expected_bins [$];
    int                    err_count;
    int unsigned           items_sent;
    bit                    tx_idle_mode;
    bit                    rx_idle_mode;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // update the local histogram for one accepted transfer; drains queue a result
    function automatic void histogram_apply(input logic op, input logic [SYM_W-1:0] sym);
        bin_result_t     res;
        longint unsigned c;
        int              k;
        if (op == OP_COUNT) begin
            if (sym < BINS) begin
                if (bin_tally[sym] == '0) occupied_bins++;
                if (bin_tally[sym] != {COUNT_BITS{1'b1}}) bin_tally[sym]++;
            end
            return;
        end
        res = '0;
        res.last = 1'b1;
        for (k = 0; k < BINS; k++) begin
            if (bin_tally[k] != '0) break;
        end
        if (k < BINS) begin
            c = bin_tally[k];
            if (c > 65535) c = 65535;
            res.sym   = k[SYM_W-1:0];
            res.count = c[OUT_COUNT_W-1:0];
            res.valid = 1'b1;
            bin_tally[k] = '0;
            occupied_bins--;
            res.last = (occupied_bins == 0);
        end
        expected_bins.push_back(res);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic op, input logic [SYM_W-1:0] sym);
        int unsigned gap;
        gap = pick_gap(tx_idle_mode);
        repeat (gap) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = sym;
        do @(posedge aclk); while (!s_tready);
        histogram_apply(op, sym);
        items_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tdata  = S_TDATA_W'($urandom);
        s_tuser  = 1'($urandom);
    endtask

    task automatic wait_results_done();
        while (expected_bins.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // result side: random backpressure
    initial begin
        int unsigned stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left != 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap(rx_idle_mode);
            end
        end
    end

    always @(posedge aclk) begin
        bin_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bins.size() == 0) begin
                $error("unexpected result transfer: tdata=%h tuser=%b tlast=%b",
                       m_tdata, m_tuser, m_tlast);
                err_count++;
            end else begin
                want = expected_bins.pop_front();
                if (m_tdata[SYM_W-1:0] !== want.sym) begin
                    $error("bin_symbol: expected %0d, actual %0d",
                           want.sym, m_tdata[SYM_W-1:0]);
                    err_count++;
                end
                if (m_tdata[SYM_W +: OUT_COUNT_W] !== want.count) begin
                    $error("bin_count: expected %0d, actual %0d",
                           want.count, m_tdata[SYM_W +: OUT_COUNT_W]);
                    err_count++;
                end
                if (m_tuser[0] !== want.valid) begin
                    $error("bin_valid: expected %0b, actual %0b", want.valid, m_tuser[0]);
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("drain_last: expected %0b, actual %0b", want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    task automatic test_empty_drain();
        tx_idle_mode = 1'b0;
        rx_idle_mode = 1'b0;
        send_item(OP_DRAIN, 8'hFF);
        send_item(OP_DRAIN, 8'h00);
        wait_results_done();
    endtask

    // lowest and highest symbols, alternating bit patterns, full drain then empty
    task automatic test_symbol_extremes();
        tx_idle_mode = 1'b1;
        rx_idle_mode = 1'b1;
        send_item(OP_COUNT, 8'h00);
        send_item(OP_COUNT, 8'hFF);
        send_item(OP_COUNT, 8'hFF);
        send_item(OP_COUNT, 8'h80);
        send_item(OP_COUNT, 8'h01);
        send_item(OP_COUNT, 8'hAA);
        send_item(OP_COUNT, 8'h55);
        send_item(OP_COUNT, 8'h7F);
        repeat (8) send_item(OP_DRAIN, SYM_W'($urandom));
        wait_results_done();
    endtask

    task automatic test_count_burst();
        tx_idle_mode = 1'b0;
        rx_idle_mode = 1'b0;
        send_item(OP_COUNT, 8'h3C);
        repeat (BURST_LEN) send_item(OP_COUNT, 8'hC3);
        repeat (3) send_item(OP_DRAIN, SYM_W'($urandom));
        wait_results_done();
    endtask

    task automatic random_round();
        int unsigned n;
        int unsigned kind;
        logic [SYM_W-1:0] base;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            // noise: free mix of counts and drains
            n = $urandom_range(4, 20);
            repeat (n) send_item(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)));
        end else begin
            n    = $urandom_range(1, 30);
            base = SYM_W'($urandom_range(0, 255));
            // half the symbols from a narrow window so bins collect real counts
            repeat (n) begin
                if ($urandom_range(0, 1) == 0)
                    send_item(OP_COUNT, base + SYM_W'($urandom_range(0, 7)));
                else
                    send_item(OP_COUNT, SYM_W'($urandom_range(0, 255)));
            end
            if (kind < 7) begin
                while (occupied_bins != 0) send_item(OP_DRAIN, SYM_W'($urandom));
                if ($urandom_range(0, 2) == 0) send_item(OP_DRAIN, SYM_W'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) send_item(OP_DRAIN, SYM_W'($urandom));
            end
        end
        if ($urandom_range(0, 7) == 0) wait_results_done();
    endtask

    task automatic test_random_traffic();
        int unsigned start;
        int          phase;
        start = items_sent;
        for (phase = 0; phase < 4; phase++) begin
            tx_idle_mode = phase[0];
            rx_idle_mode = phase[1];
            while (items_sent < start + (phase + 1) * RANDOM_ITEMS / 4) random_round();
            wait_results_done();
        end
        while (occupied_bins != 0) send_item(OP_DRAIN, SYM_W'($urandom));
        wait_results_done();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        tx_idle_mode  = 1'b0;
        rx_idle_mode  = 1'b0;
        err_count     = 0;
        items_sent    = 0;
        occupied_bins = 0;
        foreach (bin_tally[k]) bin_tally[k] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_drain();
        test_symbol_extremes();
        test_count_burst();
        test_random_traffic();

        wait_results_done();
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bhd_pkg.sv
hw/rtl/bhd_ctrl.sv
hw/rtl/bhd_dp.sv
hw/rtl/byte_histogram_drain_unit.sv
sim/tb.sv
